@@ design/ecas_pkg.sv @@
// Shared types and constants for the encoder clock and alarm setter.
package ecas_pkg;

	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_ADDR_W-1:0] ADDR_TWENTY_FOUR_HOUR = 3'd0;

	localparam logic [5:0]  SEC_MAX      = 6'd59;
	localparam logic [5:0]  MIN_MAX      = 6'd59;
	localparam logic [4:0]  HOUR_MAX     = 5'd23;
	localparam logic [4:0]  HOUR_NOON    = 5'd12;
	localparam logic [13:0] FREQ_RESET   = 14'd9910;
	localparam logic [13:0] FREQ_UP_LIM  = 14'd10770;
	localparam logic [13:0] FREQ_DN_LIM  = 14'd8830;
	localparam logic [13:0] FREQ_STEP    = 14'd20;
	localparam logic [13:0] FREQ_LOW     = 14'd8810;
	localparam logic [13:0] FREQ_HIGH    = 14'd10790;
	localparam logic [7:0]  VOL_RESET    = 8'd90;
	localparam logic [7:0]  VOL_UP_LIM   = 8'd148;
	localparam logic [7:0]  VOL_MAX      = 8'd158;
	localparam logic [7:0]  VOL_STEP     = 8'd10;

	localparam logic [1:0]  PHASE_IDLE   = 2'b00;
	localparam logic [1:0]  PHASE_UP     = 2'b01;
	localparam logic [1:0]  PHASE_DOWN   = 2'b10;

	typedef enum logic {
		MODE_ENCODER = 1'b0,
		MODE_TICK    = 1'b1
	} mode_t;

	typedef enum logic [1:0] {
		TGT_CLOCK  = 2'd0,
		TGT_ALARM  = 2'd1,
		TGT_FREQ   = 2'd2,
		TGT_VOLUME = 2'd3
	} target_t;

	typedef struct packed {
		mode_t      mode;
		logic [1:0] hour_knob_phase;
		logic [1:0] minute_knob_phase;
		target_t    target;
		logic       radio_enabled;
	} item_t;

	typedef struct packed {
		logic [4:0]  hours_now;
		logic [5:0]  minutes_now;
		logic [5:0]  seconds_now;
		logic [4:0]  wake_hour;
		logic [5:0]  wake_minute;
		logic [13:0] tuned_frequency;
		logic [7:0]  volume_level;
		logic        retune;
		logic        alarm_match;
	} result_t;

	typedef struct packed {
		logic [5:0] minute;
		logic [4:0] hour;
	} hm_t;

	typedef struct packed {
		logic [5:0]  second_count;
		hm_t         clock_time;
		hm_t         alarm_time;
		logic [13:0] frequency_value;
		logic [7:0]  volume_value;
		logic [1:0]  last_hour_phase;
		logic [1:0]  last_minute_phase;
	} state_t;

endpackage

@@ design/ecas_cfg.sv @@
// Configuration register file behind the APB-style port.
module ecas_cfg import ecas_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [CFG_DATA_W-1:0] pwdata,
	output logic [CFG_DATA_W-1:0] prdata,
	output logic                  pready,
	output logic                  twenty_four_hour
);

	logic tfh_q;
	logic wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tfh_q <= 1'b1;
		end else if (wr_en && paddr == ADDR_TWENTY_FOUR_HOUR) begin
			tfh_q <= pwdata[0];
		end
	end

	always_comb begin
		unique case (paddr)
			ADDR_TWENTY_FOUR_HOUR: prdata = {{(CFG_DATA_W-1){1'b0}}, tfh_q};
			default:               prdata = '0;
		endcase
	end

	assign twenty_four_hour = tfh_q;

endmodule

@@ design/ecas_time_adj.sv @@
// Minute and hour adjust from the two encoders for one time of day.
module ecas_time_adj import ecas_pkg::*; (
	input  hm_t        time_in,
	input  logic [1:0] hour_phase,
	input  logic [1:0] minute_phase,
	input  logic [1:0] last_hour_phase,
	input  logic [1:0] last_minute_phase,
	input  logic       twenty_four_hour,
	output hm_t        time_out
);

	logic       min_up, min_dn, hr_up, hr_dn;
	logic [4:0] hour_inc, hour_dec;

	assign min_up = (last_minute_phase == PHASE_IDLE) && (minute_phase == PHASE_UP);
	assign min_dn = (last_minute_phase == PHASE_IDLE) && (minute_phase == PHASE_DOWN);
	assign hr_up  = (last_hour_phase == PHASE_IDLE) && (hour_phase == PHASE_UP);
	assign hr_dn  = (last_hour_phase == PHASE_IDLE) && (hour_phase == PHASE_DOWN);

	assign hour_inc = (time_in.hour >= HOUR_MAX) ? 5'd0 : time_in.hour + 5'd1;
	assign hour_dec = (time_in.hour == 5'd0) ? HOUR_MAX : time_in.hour - 5'd1;

	always_comb begin
		time_out = time_in;
		if (minute_phase != last_minute_phase) begin
			if (min_up) begin
				if (time_in.minute >= MIN_MAX) begin
					time_out.minute = 6'd0;
					time_out.hour   = hour_inc;
				end else begin
					time_out.minute = time_in.minute + 6'd1;
				end
			end else if (min_dn) begin
				if (time_in.minute == 6'd0) begin
					time_out.minute = MIN_MAX;
					time_out.hour   = hour_dec;
				end else begin
					time_out.minute = time_in.minute - 6'd1;
				end
				if (time_out.hour == 5'd0 && !twenty_four_hour) begin
					time_out.hour = HOUR_NOON;
				end
			end
		end else if (hour_phase != last_hour_phase) begin
			if (hr_up) begin
				time_out.hour = hour_inc;
			end else if (hr_dn) begin
				time_out.hour = (hour_dec == 5'd0 && !twenty_four_hour) ? HOUR_NOON : hour_dec;
			end
		end
	end

endmodule

@@ design/ecas_update.sv @@
// Next-state and result logic for one registered input beat.
module ecas_update import ecas_pkg::*; (
	input  state_t  cur,
	input  item_t   item,
	input  logic    twenty_four_hour,
	output state_t  nxt,
	output result_t res
);

	hm_t  adj_in, adj_out;
	logic enc_up, enc_dn;
	logic retune;

	assign adj_in = (item.target == TGT_ALARM) ? cur.alarm_time : cur.clock_time;

	ecas_time_adj u_time_adj (
		.time_in           (adj_in),
		.hour_phase        (item.hour_knob_phase),
		.minute_phase      (item.minute_knob_phase),
		.last_hour_phase   (cur.last_hour_phase),
		.last_minute_phase (cur.last_minute_phase),
		.twenty_four_hour  (twenty_four_hour),
		.time_out          (adj_out)
	);

	assign enc_up = (cur.last_minute_phase == PHASE_IDLE) && (item.minute_knob_phase == PHASE_UP);
	assign enc_dn = (cur.last_minute_phase == PHASE_IDLE) && (item.minute_knob_phase == PHASE_DOWN);

	always_comb begin
		nxt    = cur;
		retune = 1'b0;
		if (item.mode == MODE_TICK) begin
			if (cur.second_count >= SEC_MAX) begin
				nxt.second_count = 6'd0;
				if (cur.clock_time.minute >= MIN_MAX) begin
					nxt.clock_time.minute = 6'd0;
					nxt.clock_time.hour   = (cur.clock_time.hour >= HOUR_MAX) ? 5'd0 :
						cur.clock_time.hour + 5'd1;
				end else begin
					nxt.clock_time.minute = cur.clock_time.minute + 6'd1;
				end
			end else begin
				nxt.second_count = cur.second_count + 6'd1;
			end
		end else begin
			unique case (item.target)
				TGT_CLOCK: nxt.clock_time = adj_out;
				TGT_ALARM: nxt.alarm_time = adj_out;
				TGT_FREQ: begin
					if (enc_up && cur.frequency_value <= FREQ_UP_LIM) begin
						nxt.frequency_value = cur.frequency_value + FREQ_STEP;
					end else if (enc_dn && cur.frequency_value >= FREQ_DN_LIM) begin
						nxt.frequency_value = cur.frequency_value - FREQ_STEP;
					end
					retune = (enc_up || enc_dn) && item.radio_enabled;
				end
				TGT_VOLUME: begin
					if (enc_up) begin
						nxt.volume_value = (cur.volume_value < VOL_UP_LIM) ?
							cur.volume_value + VOL_STEP : VOL_MAX;
					end else if (enc_dn) begin
						nxt.volume_value = (cur.volume_value > VOL_STEP) ?
							cur.volume_value - VOL_STEP : 8'd0;
					end
				end
				default: ;
			endcase
			nxt.last_hour_phase   = item.hour_knob_phase;
			nxt.last_minute_phase = item.minute_knob_phase;
		end
	end

	always_comb begin
		res.hours_now       = nxt.clock_time.hour;
		res.minutes_now     = nxt.clock_time.minute;
		res.seconds_now     = nxt.second_count;
		res.wake_hour       = nxt.alarm_time.hour;
		res.wake_minute     = nxt.alarm_time.minute;
		res.tuned_frequency = nxt.frequency_value;
		res.volume_level    = nxt.volume_value;
		res.retune          = retune;
		res.alarm_match     = (nxt.clock_time == nxt.alarm_time);
	end

endmodule

@@ design/encoder_clock_alarm_setter.sv @@
// Top level of the encoder clock and alarm setter.
//
// Input channel item/item_valid/item_stall carries one beat per encoder sample
// or one-second tick. Output channel result/result_valid/result_stall returns
// one beat per input beat with the clock, alarm, frequency and volume after
// the update, plus the retune and alarm match flags.
// An input beat lands in the input register; the state update runs on it and
// the result register loads once the output has room, so a result follows its
// input beat through both registers. One beat per cycle is taken while the
// output flows, set by the single state update between the two registers.
// When the receiver stalls, the result register holds and the input register
// fills; item_stall rises only while both are full and the output is stalled.
// The APB-style port holds twenty_four_hour at byte address 0; pready is
// always high and writes land at the access cycle.
// Reset clears both pipeline valids and puts the clock and alarm at 00:00,
// the frequency at 9910, the volume at 90 and 24-hour mode on.
module encoder_clock_alarm_setter import ecas_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	output logic                  item_stall,
	input  item_t                 item,
	output logic                  result_valid,
	input  logic                  result_stall,
	output result_t               result,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [CFG_DATA_W-1:0] pwdata,
	output logic [CFG_DATA_W-1:0] prdata,
	output logic                  pready
);

	logic    twenty_four_hour;
	logic    valid_s1, valid_s2;
	item_t   item_s1;
	result_t result_s2;
	state_t  state_q, state_nxt;
	result_t res_nxt;
	logic    adv_s1, take_in;

	ecas_cfg u_cfg (
		.clk              (clk),
		.arst_n           (arst_n),
		.psel             (psel),
		.penable          (penable),
		.pwrite           (pwrite),
		.paddr            (paddr),
		.pwdata           (pwdata),
		.prdata           (prdata),
		.pready           (pready),
		.twenty_four_hour (twenty_four_hour)
	);

	ecas_update u_update (
		.cur              (state_q),
		.item             (item_s1),
		.twenty_four_hour (twenty_four_hour),
		.nxt              (state_nxt),
		.res              (res_nxt)
	);

	assign adv_s1     = valid_s1 && (!valid_s2 || !result_stall);
	assign item_stall = valid_s1 && !adv_s1;
	assign take_in    = item_valid && !item_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (take_in) begin
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s1) begin
				valid_s2 <= 1'b1;
			end else if (!result_stall) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			item_s1 <= item;
		end
		if (adv_s1) begin
			result_s2 <= res_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{
				second_count:      6'd0,
				clock_time:        '0,
				alarm_time:        '0,
				frequency_value:   FREQ_RESET,
				volume_value:      VOL_RESET,
				last_hour_phase:   PHASE_IDLE,
				last_minute_phase: PHASE_IDLE
			};
		end else if (adv_s1) begin
			state_q <= state_nxt;
		end
	end

	assign result_valid = valid_s2;
	assign result       = result_s2;

`ifndef SYNTHESIS
	a_freq_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.frequency_value >= FREQ_LOW && state_q.frequency_value <= FREQ_HIGH)
		else $error("frequency out of range");

	a_vol_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.volume_value <= VOL_MAX)
		else $error("volume out of range");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> valid_s1 && valid_s2 && result_stall)
		else $error("input stalled with room in the pipeline");

	a_match: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.alarm_match ==
			(result.hours_now == result.wake_hour && result.minutes_now == result.wake_minute))
		else $error("alarm match disagrees with result times");
`endif

endmodule
